[sv/lbrf_pkg.sv]
`timescale 1ns / 1ps

package lbrf_pkg;

  // Default word width of every momentum and energy field.
  localparam int WORD_BITS = 32;

  typedef enum logic [1:0] {
    FAULT_OK   = 2'd0,
    FAULT_PASS = 2'd1,
    FAULT_SAT  = 2'd2,
    FAULT_REST = 2'd3
  } fault_e;

  // Status of one divider result.
  typedef struct packed {
    logic neg;
    logic ovf;
  } div_flags_t;

endpackage

[sv/lbrf_chan_if.sv]
`timescale 1ns / 1ps

interface lbrf_in_if #(
  parameter int WORD_BITS = lbrf_pkg::WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] part_px;
  logic signed [WORD_BITS-1:0] part_py;
  logic signed [WORD_BITS-1:0] part_pz;
  logic signed [WORD_BITS-1:0] part_energy;
  logic signed [WORD_BITS-1:0] sys_px;
  logic signed [WORD_BITS-1:0] sys_py;
  logic signed [WORD_BITS-1:0] sys_pz;
  logic signed [WORD_BITS-1:0] sys_energy;

  modport source (
    output valid, part_px, part_py, part_pz, part_energy,
    output sys_px, sys_py, sys_pz, sys_energy,
    input  ready
  );
  modport sink (
    input  valid, part_px, part_py, part_pz, part_energy,
    input  sys_px, sys_py, sys_pz, sys_energy,
    output ready
  );
endinterface

interface lbrf_out_if #(
  parameter int WORD_BITS = lbrf_pkg::WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] out_px;
  logic signed [WORD_BITS-1:0] out_py;
  logic signed [WORD_BITS-1:0] out_pz;
  logic signed [WORD_BITS-1:0] out_energy;
  logic [1:0]                  fault;

  modport source (
    output valid, out_px, out_py, out_pz, out_energy, fault,
    input  ready
  );
  modport sink (
    input  valid, out_px, out_py, out_pz, out_energy, fault,
    output ready
  );
endinterface

[sv/lorentz_boost_rest_frame_unit.sv]
`timescale 1ns / 1ps

// Lorentz boost of a particle four-momentum into the rest frame of a system
// four-momentum, all fields signed fixed point of WORD_BITS bits. The unit is
// a single streaming pipeline: it takes one item per clock unless held, and
// returns one result per item, in order. Its depth is set by the bit-serial
// stages: the mass square root spends one stage per root bit, and each of the
// two divider passes (rest-frame energy, then the three momentum corrections
// in parallel lanes) spends one stage per quotient bit plus an entry stage.
// The whole pipeline advances together; it holds only while a result sits in
// the output register and the sink is not ready. fault reports 3 when the
// system momentum is zero and 1 when the mass or Es+m is zero (particle
// passed unchanged in both cases), 2 when any output was clamped, otherwise 0.
module lorentz_boost_rest_frame_unit #(
  parameter int WORD_BITS = lbrf_pkg::WORD_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbrf_in_if.sink       in_i,
  lbrf_out_if.source    out_o
);

  localparam int W      = WORD_BITS;
  localparam int PKW    = 8 * W;           // packed input fields
  localparam int DOTW   = 2 * W + 2;       // four-term product sums
  localparam int SQ_SBW = DOTW + 2 + PKW;
  localparam int D1_SBW = (W + 2) + 2 + PKW;
  localparam int CMW    = 2 * W + 3;       // e, pf, pf overflow, zero, rest
  localparam int DLAT   = W + 1;           // divider latency

  localparam logic signed [W-1:0] SatMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SatMin = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic out_vld_q;

  // Advance everything unless a finished item waits at the output.
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------------------------------------------------------- stage A
  // Packed fields: px, py, pz, e, sx, sy, sz, es from bit 0 upward.
  logic signed [W-1:0] ip [3];
  logic signed [W-1:0] is [3];
  logic [PKW-1:0]      pk_in;

  assign ip[0] = in_i.part_px;
  assign ip[1] = in_i.part_py;
  assign ip[2] = in_i.part_pz;
  assign is[0] = in_i.sys_px;
  assign is[1] = in_i.sys_py;
  assign is[2] = in_i.sys_pz;
  assign pk_in = {in_i.sys_energy, in_i.sys_pz, in_i.sys_py, in_i.sys_px,
                  in_i.part_energy, in_i.part_pz, in_i.part_py, in_i.part_px};

  logic                  vld_a_q;
  logic [PKW-1:0]        pk_a_q;
  logic                  rest_a_q;
  logic signed [2*W-1:0] ee_a_q;
  logic signed [2*W-1:0] de_a_q;
  logic signed [2*W-1:0] ss_a_q [3];
  logic signed [2*W-1:0] ps_a_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= in_i.valid;
    end
  end

  // Form every product of the mass square and the dot product at once.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_a_q   <= pk_in;
      rest_a_q <= (is[0] == '0) && (is[1] == '0) && (is[2] == '0);
      ee_a_q   <= in_i.sys_energy * in_i.sys_energy;
      de_a_q   <= in_i.part_energy * in_i.sys_energy;
      for (int i = 0; i < 3; i++) begin
        ss_a_q[i] <= is[i] * is[i];
        ps_a_q[i] <= ip[i] * is[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage B
  logic                   vld_b_q;
  logic [PKW-1:0]         pk_b_q;
  logic                   rest_b_q;
  logic signed [DOTW-1:0] m2_b_q;
  logic signed [DOTW-1:0] dot_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_b_q   <= pk_a_q;
      rest_b_q <= rest_a_q;
      m2_b_q   <= DOTW'(ee_a_q) - DOTW'(ss_a_q[0]) - DOTW'(ss_a_q[1]) - DOTW'(ss_a_q[2]);
      dot_b_q  <= DOTW'(de_a_q) - DOTW'(ps_a_q[0]) - DOTW'(ps_a_q[1]) - DOTW'(ps_a_q[2]);
    end
  end

  // --------------------------------------------------------------- stage B2
  // Take the magnitude of m^2; it always fits 2*W bits.
  logic                   vld_g_q;
  logic [PKW-1:0]         pk_g_q;
  logic                   rest_g_q;
  logic                   mneg_g_q;
  logic signed [DOTW-1:0] dot_g_q;
  logic [2*W-1:0]         rad_g_q;
  logic [DOTW-1:0]        m2_mag;

  assign m2_mag = m2_b_q[DOTW-1] ? DOTW'(-m2_b_q) : DOTW'(m2_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_g_q <= 1'b0;
    end else if (en) begin
      vld_g_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_g_q   <= pk_b_q;
      rest_g_q <= rest_b_q;
      mneg_g_q <= m2_b_q[DOTW-1];
      dot_g_q  <= dot_b_q;
      rad_g_q  <= m2_mag[2*W-1:0];
    end
  end

  // ------------------------------------------------------------ square root
  logic              vld_s;
  logic [W-1:0]      root_s;
  logic [SQ_SBW-1:0] sb_s;

  lbrf_sqrt #(
    .RW  (W),
    .SBW (SQ_SBW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_g_q),
    .rad_i  (rad_g_q),
    .sb_i   ({dot_g_q, mneg_g_q, rest_g_q, pk_g_q}),
    .vld_o  (vld_s),
    .root_o (root_s),
    .sb_o   (sb_s)
  );

  // ---------------------------------------------------------------- stage C
  // Signed mass, the Es+m divisor and the zero-divisor check.
  logic signed [W:0]   m_c;
  logic signed [W+1:0] den_c;
  logic signed [W-1:0] es_s;

  assign es_s  = sb_s[7*W +: W];
  assign m_c   = sb_s[PKW+1] ? -$signed({1'b0, root_s}) : $signed({1'b0, root_s});
  assign den_c = $signed({{2{es_s[W-1]}}, es_s}) + $signed({m_c[W], m_c});

  logic                   vld_c_q;
  logic [PKW-1:0]         pk_c_q;
  logic                   rest_c_q;
  logic                   zero_c_q;
  logic signed [DOTW-1:0] dot_c_q;
  logic signed [W:0]      m_c_q;
  logic signed [W+1:0]    den_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (en) begin
      vld_c_q <= vld_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_c_q   <= sb_s[PKW-1:0];
      rest_c_q <= sb_s[PKW];
      zero_c_q <= (root_s == '0) || (den_c == '0);
      dot_c_q  <= sb_s[SQ_SBW-1 -: DOTW];
      m_c_q    <= m_c;
      den_c_q  <= den_c;
    end
  end

  // ------------------------------------------------------- energy divider
  logic                 vld_v;
  logic [W-1:0]         quo_v;
  lbrf_pkg::div_flags_t fl_v;
  logic [D1_SBW-1:0]    sb_v;

  lbrf_div #(
    .NW  (DOTW),
    .DW  (W + 1),
    .QW  (W),
    .SBW (D1_SBW)
  ) u_div_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld_c_q),
    .num_i   (dot_c_q),
    .den_i   (m_c_q),
    .sb_i    ({den_c_q, zero_c_q, rest_c_q, pk_c_q}),
    .vld_o   (vld_v),
    .quo_o   (quo_v),
    .flags_o (fl_v),
    .sb_o    (sb_v)
  );

  // ---------------------------------------------------------------- stage D
  // Sign and clamp the rest-frame energy.
  logic signed [W:0]   pf_full;
  logic signed [W-1:0] pf_d;
  logic                pfo_d;

  assign pf_full = fl_v.neg ? -$signed({1'b0, quo_v}) : $signed({1'b0, quo_v});

  always_comb begin
    if (fl_v.ovf) begin
      pf_d  = fl_v.neg ? SatMin : SatMax;
      pfo_d = 1'b1;
    end else if (pf_full[W] != pf_full[W-1]) begin
      pf_d  = pf_full[W] ? SatMin : SatMax;
      pfo_d = 1'b1;
    end else begin
      pf_d  = pf_full[W-1:0];
      pfo_d = 1'b0;
    end
  end

  logic                vld_d_q;
  logic [PKW-1:0]      pk_d_q;
  logic                rest_d_q;
  logic                zero_d_q;
  logic signed [W+1:0] den_d_q;
  logic signed [W-1:0] pf_d_q;
  logic                pfo_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (en) begin
      vld_d_q <= vld_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_d_q   <= sb_v[PKW-1:0];
      rest_d_q <= sb_v[PKW];
      zero_d_q <= sb_v[PKW+1];
      den_d_q  <= sb_v[D1_SBW-1 -: (W + 2)];
      pf_d_q   <= pf_d;
      pfo_d_q  <= pfo_d;
    end
  end

  // ---------------------------------------------------------------- stage N
  // E' + E for the momentum correction.
  logic signed [W-1:0] e_d;

  assign e_d = pk_d_q[3*W +: W];

  logic                vld_n_q;
  logic [PKW-1:0]      pk_n_q;
  logic                rest_n_q;
  logic                zero_n_q;
  logic signed [W+1:0] den_n_q;
  logic signed [W-1:0] pf_n_q;
  logic                pfo_n_q;
  logic signed [W:0]   nsum_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_n_q <= 1'b0;
    end else if (en) begin
      vld_n_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_n_q   <= pk_d_q;
      rest_n_q <= rest_d_q;
      zero_n_q <= zero_d_q;
      den_n_q  <= den_d_q;
      pf_n_q   <= pf_d_q;
      pfo_n_q  <= pfo_d_q;
      nsum_n_q <= $signed({pf_d_q[W-1], pf_d_q}) + $signed({e_d[W-1], e_d});
    end
  end

  // ---------------------------------------------------------------- stage E
  // Correction numerators (E' + E) * ps_i.
  logic signed [W-1:0] s_n [3];

  for (genvar i = 0; i < 3; i++) begin : g_sn
    assign s_n[i] = pk_n_q[(4 + i) * W +: W];
  end

  logic                  vld_e_q;
  logic [PKW-1:0]        pk_e_q;
  logic signed [W+1:0]   den_e_q;
  logic [CMW-1:0]        cm_e_q;
  logic signed [2*W:0]   prod_e_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else if (en) begin
      vld_e_q <= vld_n_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_e_q  <= pk_n_q;
      den_e_q <= den_n_q;
      cm_e_q  <= {pk_n_q[3*W +: W], pf_n_q, pfo_n_q, zero_n_q, rest_n_q};
      for (int i = 0; i < 3; i++) begin
        prod_e_q[i] <= nsum_n_q * s_n[i];
      end
    end
  end

  // ------------------------------------------- momentum divider lanes
  logic                 lane_vld [3];
  logic [W-1:0]         lane_quo [3];
  lbrf_pkg::div_flags_t lane_fl  [3];
  logic [W-1:0]         lane_p   [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    lbrf_div #(
      .NW  (2 * W + 1),
      .DW  (W + 2),
      .QW  (W),
      .SBW (W)
    ) u_div_p (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .vld_i   (vld_e_q),
      .num_i   (prod_e_q[i]),
      .den_i   (den_e_q),
      .sb_i    (pk_e_q[i*W +: W]),
      .vld_o   (lane_vld[i]),
      .quo_o   (lane_quo[i]),
      .flags_o (lane_fl[i]),
      .sb_o    (lane_p[i])
    );
  end

  // Carry the per-item common fields alongside the lanes.
  logic [CMW-1:0] cm_dl_q [DLAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cm_dl_q[0] <= cm_e_q;
      for (int k = 1; k < DLAT; k++) begin
        cm_dl_q[k] <= cm_dl_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage F
  // p_i minus its correction, clamped to the word range.
  logic signed [W-1:0] lane_res [3];
  logic                lane_ovf [3];

  for (genvar i = 0; i < 3; i++) begin : g_res
    logic signed [W:0]   corr;
    logic signed [W+1:0] diff;
    logic signed [W-1:0] pv;

    assign pv   = lane_p[i];
    assign corr = lane_fl[i].neg ? -$signed({1'b0, lane_quo[i]})
                                 :  $signed({1'b0, lane_quo[i]});
    assign diff = $signed({{2{pv[W-1]}}, pv}) - $signed({corr[W], corr});

    always_comb begin
      if (lane_fl[i].ovf) begin
        // A huge correction drives the difference past the opposite rail.
        lane_res[i] = lane_fl[i].neg ? SatMax : SatMin;
        lane_ovf[i] = 1'b1;
      end else if ((diff[W+1:W-1] != '0) && (diff[W+1:W-1] != '1)) begin
        lane_res[i] = diff[W+1] ? SatMin : SatMax;
        lane_ovf[i] = 1'b1;
      end else begin
        lane_res[i] = diff[W-1:0];
        lane_ovf[i] = 1'b0;
      end
    end
  end

  logic signed [W-1:0] cm_e;
  logic signed [W-1:0] cm_pf;
  logic                cm_pfo;
  logic                cm_zero;
  logic                cm_rest;

  assign {cm_e, cm_pf, cm_pfo, cm_zero, cm_rest} = cm_dl_q[DLAT-1];

  logic signed [W-1:0] px_d;
  logic signed [W-1:0] py_d;
  logic signed [W-1:0] pz_d;
  logic signed [W-1:0] en_out_d;
  lbrf_pkg::fault_e    fault_d;

  // Pass the particle through at rest or on a zero divisor, else boost.
  always_comb begin
    if (cm_rest || cm_zero) begin
      px_d     = lane_p[0];
      py_d     = lane_p[1];
      pz_d     = lane_p[2];
      en_out_d = cm_e;
      fault_d  = cm_rest ? lbrf_pkg::FAULT_REST : lbrf_pkg::FAULT_PASS;
    end else begin
      px_d     = lane_res[0];
      py_d     = lane_res[1];
      pz_d     = lane_res[2];
      en_out_d = cm_pf;
      fault_d  = (cm_pfo || lane_ovf[0] || lane_ovf[1] || lane_ovf[2])
                 ? lbrf_pkg::FAULT_SAT : lbrf_pkg::FAULT_OK;
    end
  end

  logic signed [W-1:0] out_px_q;
  logic signed [W-1:0] out_py_q;
  logic signed [W-1:0] out_pz_q;
  logic signed [W-1:0] out_en_q;
  lbrf_pkg::fault_e    fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= lane_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_px_q <= px_d;
      out_py_q <= py_d;
      out_pz_q <= pz_d;
      out_en_q <= en_out_d;
      fault_q  <= fault_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_px     = out_px_q;
  assign out_o.out_py     = out_py_q;
  assign out_o.out_pz     = out_pz_q;
  assign out_o.out_energy = out_en_q;
  assign out_o.fault      = fault_q;

  // ------------------------------------------------------------ assertions
  // The three momentum lanes run in lockstep.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_vld[0] == lane_vld[1]) && (lane_vld[1] == lane_vld[2]))
    else $error("momentum divider lanes out of step");

  // A saturation fault means at least one field sits on a rail.
  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (fault_q == lbrf_pkg::FAULT_SAT)) |->
      ((out_px_q == SatMax) || (out_px_q == SatMin) ||
       (out_py_q == SatMax) || (out_py_q == SatMin) ||
       (out_pz_q == SatMax) || (out_pz_q == SatMin) ||
       (out_en_q == SatMax) || (out_en_q == SatMin)))
    else $error("saturation fault without a clamped field");

endmodule

[sv/lbrf_sqrt.sv]
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage, floor result.
module lbrf_sqrt #(
  parameter int RW  = lbrf_pkg::WORD_BITS,
  parameter int SBW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            vld_o,
  output logic [RW-1:0]   root_o,
  output logic [SBW-1:0]  sb_o
);

  logic            vld_q  [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [SBW-1:0]  sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            vin;
    logic [RW+1:0]   rin;
    logic [RW-1:0]   tin;
    logic [2*RW-1:0] xin;
    logic [SBW-1:0]  sin;
    logic [RW+3:0]   cur;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign vin = vld_i;
      assign rin = '0;
      assign tin = '0;
      assign xin = rad_i;
      assign sin = sb_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign rin = rem_q[k-1];
      assign tin = root_q[k-1];
      assign xin = rad_q[k-1];
      assign sin = sb_q[k-1];
    end

    // Bring down two radicand bits, try root*4+1.
    assign cur   = {rin, xin[2*RW-1 -: 2]};
    assign trial = {2'b00, tin, 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[RW+1:0] : cur[RW+1:0];
        root_q[k] <= {tin[RW-2:0], ge};
        rad_q[k]  <= {xin[2*RW-3:0], 2'b00};
        sb_q[k]   <= sin;
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign sb_o   = sb_q[RW-1];

endmodule

[sv/lbrf_div.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Flags an overflow when the quotient magnitude needs more than QW bits.
module lbrf_div #(
  parameter int NW  = 2 * lbrf_pkg::WORD_BITS + 2,
  parameter int DW  = lbrf_pkg::WORD_BITS + 1,
  parameter int QW  = lbrf_pkg::WORD_BITS,
  parameter int SBW = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic signed [NW-1:0]     num_i,
  input  logic signed [DW-1:0]     den_i,
  input  logic [SBW-1:0]           sb_i,
  output logic                     vld_o,
  output logic [QW-1:0]            quo_o,
  output lbrf_pkg::div_flags_t     flags_o,
  output logic [SBW-1:0]           sb_o
);

  localparam int HW = NW - QW;

  logic [NW-1:0]    nmag;
  logic [DW-1:0]    dmag;
  logic [HW+DW-1:0] hi_x;
  logic [HW+DW-1:0] dm_x;

  assign nmag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign dmag = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
  assign hi_x = {{DW{1'b0}}, nmag[NW-1:QW]};
  assign dm_x = {{HW{1'b0}}, dmag};

  logic                 vld_q [QW+1];
  logic [DW-1:0]        rem_q [QW+1];
  logic [QW-1:0]        low_q [QW+1];
  logic [DW-1:0]        dm_q  [QW+1];
  lbrf_pkg::div_flags_t fl_q  [QW+1];
  logic [SBW-1:0]       sb_q  [QW+1];

  // Entry stage: magnitudes, sign and the overflow test on the high part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_x[DW-1:0];
      low_q[0] <= nmag[QW-1:0];
      dm_q[0]  <= dmag;
      fl_q[0]  <= '{neg: num_i[NW-1] ^ den_i[DW-1], ovf: (hi_x >= dm_x)};
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] sh;
    logic          ge;

    assign sh = {rem_q[k][DW-2:0], low_q[k][QW-1]};
    assign ge = (sh >= dm_q[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    // Shift numerator bits out at the top, quotient bits in at the bottom.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? (sh - dm_q[k]) : sh;
        low_q[k+1] <= {low_q[k][QW-2:0], ge};
        dm_q[k+1]  <= dm_q[k];
        fl_q[k+1]  <= fl_q[k];
        sb_q[k+1]  <= sb_q[k];
      end
    end
  end

  assign vld_o   = vld_q[QW];
  assign quo_o   = low_q[QW];
  assign flags_o = fl_q[QW];
  assign sb_o    = sb_q[QW];

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int W = lbrf_pkg::WORD_BITS;
  localparam int LATENCY = 3 * W + 10;

  typedef logic signed [W-1:0] word_t;

  // one particle/system pair as offered to the unit
  typedef struct {
    word_t px, py, pz, en;
    word_t sx, sy, sz, se;
  } pair_t;

  // one boosted four-vector as returned by the unit
  typedef struct {
    word_t            px, py, pz, en;
    lbrf_pkg::fault_e fault;
  } boosted_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lbrf_in_if  #(.WORD_BITS(W)) in_if ();
  lbrf_out_if #(.WORD_BITS(W)) out_if ();

  lorentz_boost_rest_frame_unit #(.WORD_BITS(W)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pair_t    pending_pairs[$];
  boosted_t expected_boosts[$];
  int       error_count = 0;
  int       accepted_count = 0;
  int       hold_off_cycles = 0;
  bit       hold_off_done = 1'b0;

  // Clamp a wide signed value into the word range, flag any clipping.
  function automatic word_t clamp_word(input logic signed [127:0] v, inout logic ovf);
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    hi_lim = (128'sd1 <<< (W - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) begin
      ovf = 1'b1;
      return hi_lim[W-1:0];
    end
    if (v < lo_lim) begin
      ovf = 1'b1;
      return lo_lim[W-1:0];
    end
    return v[W-1:0];
  endfunction

  // Boost the particle into the rest frame of the system, bit exact.
  function automatic boosted_t boost_to_rest(input pair_t it);
    logic signed [127:0] p[3];
    logic signed [127:0] s[3];
    logic signed [127:0] e, es, m2, dot, m, den, pf, nsum, corr;
    logic [127:0] mag, t;
    logic [63:0] root;
    logic ovf;
    boosted_t r;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    s[0] = it.sx; s[1] = it.sy; s[2] = it.sz;
    e = it.en;
    es = it.se;
    ovf = 1'b0;
    r.px = it.px; r.py = it.py; r.pz = it.pz; r.en = it.en;
    // system at rest: pass the particle through
    if (it.sx == 0 && it.sy == 0 && it.sz == 0) begin
      r.fault = lbrf_pkg::FAULT_REST;
      return r;
    end
    m2 = es * es - s[0] * s[0] - s[1] * s[1] - s[2] * s[2];
    mag = (m2 < 0) ? -m2 : m2;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      t = {64'd0, root | (64'd1 << b)};
      if (t * t <= mag) root = t[63:0];
    end
    m = $signed({64'd0, root});
    if (m2 < 0) m = -m;
    den = es + m;
    // zero mass or zero divisor: pass through
    if (m == 0 || den == 0) begin
      r.fault = lbrf_pkg::FAULT_PASS;
      return r;
    end
    dot = e * es - p[0] * s[0] - p[1] * s[1] - p[2] * s[2];
    pf = clamp_word(dot / m, ovf);
    nsum = pf + e;
    corr = (nsum * s[0]) / den;
    r.px = clamp_word(p[0] - corr, ovf);
    corr = (nsum * s[1]) / den;
    r.py = clamp_word(p[1] - corr, ovf);
    corr = (nsum * s[2]) / den;
    r.pz = clamp_word(p[2] - corr, ovf);
    r.en = pf[W-1:0];
    r.fault = ovf ? lbrf_pkg::FAULT_SAT : lbrf_pkg::FAULT_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic word_t any_word();
    return word_t'($urandom);
  endfunction

  // signed value within +/- 2^bits
  function automatic word_t signed_upto(input int bits);
    word_t v;
    v = word_t'($urandom_range((1 << bits) - 1, 0));
    return $urandom_range(1, 0) ? -v : v;
  endfunction

  // Physically sensible pair: system energy above its momentum.
  function automatic pair_t physical_pair();
    pair_t it;
    int bits;
    bits = $urandom_range(26, 8);
    it.sx = signed_upto(bits - 2);
    it.sy = signed_upto(bits - 2);
    it.sz = signed_upto(bits - 2);
    it.se = word_t'($urandom_range((1 << bits) - 1, 1 << (bits - 1)));
    it.px = signed_upto(bits);
    it.py = signed_upto(bits);
    it.pz = signed_upto(bits);
    it.en = word_t'($urandom_range((1 << bits) - 1, 0));
    return it;
  endfunction

  function automatic pair_t mk_pair(input word_t px, py, pz, en, sx, sy, sz, se);
    pair_t it;
    it.px = px; it.py = py; it.pz = pz; it.en = en;
    it.sx = sx; it.sy = sy; it.sz = sz; it.se = se;
    return it;
  endfunction

  // Driver: bursts of items separated by random gaps.
  int    burst_left = 0;
  int    gap_left = 0;
  pair_t on_bus;

  always @(posedge clk_i) begin
    logic  next_valid;
    pair_t nxt;
    next_valid = in_if.valid;
    nxt = on_bus;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_boosts.push_back(boost_to_rest(on_bus));
        accepted_count++;
        next_valid = 1'b0;
      end
      // a held item stays on the bus until taken
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pairs.size() > 0) begin
          nxt = pending_pairs.pop_front();
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(40, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end
      end
    end
    on_bus = nxt;
    in_if.valid       <= next_valid;
    in_if.part_px     <= nxt.px;
    in_if.part_py     <= nxt.py;
    in_if.part_pz     <= nxt.pz;
    in_if.part_energy <= nxt.en;
    in_if.sys_px      <= nxt.sx;
    in_if.sys_py      <= nxt.sy;
    in_if.sys_pz      <= nxt.sz;
    in_if.sys_energy  <= nxt.se;
  end

  // Long hold-off on the receive side once the pipeline is busy.
  always @(posedge clk_i) begin
    if (!hold_off_done && accepted_count >= 300) begin
      hold_off_done <= 1'b1;
      hold_off_cycles <= 400;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // Monitor: check each returned item, stall on a randomly redrawn pattern.
  int cycle_count = 0;
  int stall_mode = 0;

  always @(posedge clk_i) begin
    boosted_t want;
    logic     rdy;
    cycle_count++;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_boosts.size() == 0) begin
        report_mismatch("unexpected item", out_if.out_px, 'x);
      end else begin
        want = expected_boosts.pop_front();
        if (out_if.out_px !== want.px) report_mismatch("out_px", out_if.out_px, want.px);
        if (out_if.out_py !== want.py) report_mismatch("out_py", out_if.out_py, want.py);
        if (out_if.out_pz !== want.pz) report_mismatch("out_pz", out_if.out_pz, want.pz);
        if (out_if.out_energy !== want.en)
          report_mismatch("out_energy", out_if.out_energy, want.en);
        if (out_if.fault !== want.fault)
          report_mismatch("fault", W'(out_if.fault), W'(want.fault));
      end
    end
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(2, 0);
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(3, 0) != 0);
      default: rdy = ($urandom_range(3, 0) == 0);
    endcase
    out_if.ready <= rst_ni && rdy && (hold_off_cycles == 0);
  end

  initial begin
    word_t maxw;
    word_t minw;
    pair_t it;
    maxw = {1'b0, {(W-1){1'b1}}};
    minw = {1'b1, {(W-1){1'b0}}};
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.part_px = '0; in_if.part_py = '0; in_if.part_pz = '0; in_if.part_energy = '0;
    in_if.sys_px = '0; in_if.sys_py = '0; in_if.sys_pz = '0; in_if.sys_energy = '0;
    out_if.ready = 1'b0;

    // system at rest, including extreme particle fields
    pending_pairs.push_back(mk_pair(maxw, minw, 1, -1, 0, 0, 0, 12345));
    pending_pairs.push_back(mk_pair(minw, maxw, 0, maxw, 0, 0, 0, minw));
    // light-like system: zero mass
    pending_pairs.push_back(mk_pair(100, 200, 300, 400, 65536, 0, 0, 65536));
    pending_pairs.push_back(mk_pair(-7, 9, 11, 13, 0, -3 << 16, 4 << 16, 5 << 16));
    // spacelike system whose negative mass cancels the energy: zero divisor
    pending_pairs.push_back(mk_pair(5, 6, 7, 8, 3, 3, 0, 3));
    pending_pairs.push_back(mk_pair(5, 6, 7, 8, 3 << 8, 0, -(3 << 8), 3 << 8));
    // ordinary boosts
    pending_pairs.push_back(mk_pair(1 << 16, 2 << 16, -(3 << 16), 10 << 16,
                                    1 << 16, 0, 0, 5 << 16));
    pending_pairs.push_back(mk_pair(0, 0, 0, 1 << 16, 0, 0, 3 << 16, 5 << 16));
    // spacelike system, negative mass but nonzero divisor
    pending_pairs.push_back(mk_pair(1 << 16, 1 << 16, 1 << 16, 2 << 16,
                                    4 << 16, 0, 0, 3 << 16));
    // extremes driving saturation
    pending_pairs.push_back(mk_pair(maxw, maxw, maxw, maxw, 1, 0, 0, 2));
    pending_pairs.push_back(mk_pair(minw, minw, minw, minw, -1, 0, 0, 2));
    pending_pairs.push_back(mk_pair(maxw, minw, maxw, minw, maxw, maxw, maxw, maxw));
    pending_pairs.push_back(mk_pair(minw, minw, minw, minw, minw, minw, minw, minw));
    pending_pairs.push_back(mk_pair(maxw, maxw, maxw, maxw, minw, 0, 0, maxw));
    pending_pairs.push_back(mk_pair(-1, -1, -1, -1, 0, 0, -1, minw));

    for (int n = 0; n < 1200; n++) begin
      case ($urandom_range(9, 0))
        0, 1: begin
          // raw random words: every bit, every odd case
          it = mk_pair(any_word(), any_word(), any_word(), any_word(),
                       any_word(), any_word(), any_word(), any_word());
          if ($urandom_range(3, 0) == 0) begin
            it.sx = 0; it.sy = 0; it.sz = 0;
          end
        end
        2: begin
          // near the zero-mass line
          it = physical_pair();
          it.sy = 0; it.sz = 0;
          it.sx = $urandom_range(1, 0) ? it.se : -it.se;
        end
        default: it = physical_pair();
      endcase
      pending_pairs.push_back(it);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs.size() > 0 || in_if.valid || expected_boosts.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far above the slowest passing run.
  initial begin
    #5ms;
    $display("TIMEOUT at %0t", $realtime);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
